// ===== hw/rtl/drds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drds_pkg
// Shared types and constants for the damage rectangle set.
// ----------------------------------------------------------------------------
package drds_pkg;

    localparam int MAX_RECTS = 8;
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        w;
        logic [16:0]        h;
    } box_t;

endpackage

// ===== hw/rtl/drds_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drds_req_if
// Command channel: valid/ready plus one command word.
// ----------------------------------------------------------------------------
interface drds_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic [2:0]         entry_index;

    modport source (output valid, cmd, rect_x, rect_y, rect_w, rect_h, entry_index,
                    input ready);
    modport sink (input valid, cmd, rect_x, rect_y, rect_w, rect_h, entry_index,
                  output ready);
endinterface

// ===== hw/rtl/drds_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drds_rsp_if
// Result channel: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface drds_rsp_if;
    logic               valid;
    logic               ready;
    logic               bounds_valid;
    logic signed [15:0] bound_x;
    logic signed [15:0] bound_y;
    logic [16:0]        bound_w;
    logic [16:0]        bound_h;
    logic [31:0]        total_area;
    logic [3:0]         rect_count;
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic [16:0]        entry_w;
    logic [16:0]        entry_h;

    modport source (output valid, bounds_valid, bound_x, bound_y, bound_w, bound_h,
                    total_area, rect_count, entry_x, entry_y, entry_w, entry_h,
                    input ready);
    modport sink (input valid, bounds_valid, bound_x, bound_y, bound_w, bound_h,
                  total_area, rect_count, entry_x, entry_y, entry_w, entry_h,
                  output ready);
endinterface

// ===== hw/rtl/drds_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drds_alu
// Shared box unit: touch test, bounding-box merge, registered area multiplier.
// ----------------------------------------------------------------------------
module drds_alu
    import drds_pkg::*;
(
    input  logic        clk,
    input  box_t        a,
    input  box_t        b,
    input  logic [16:0] mul_a,
    input  logic [16:0] mul_b,
    output logic        touch,
    output box_t        merged,
    output logic [31:0] product
);

    logic signed [17:0] ax, ay, bx, by, ar, ab, br, bb, rmax, bmax, mx, my;
    logic [33:0]        prod_full;
    logic [31:0]        prod_reg;

    assign ax = {{2{a.x[15]}}, a.x};
    assign ay = {{2{a.y[15]}}, a.y};
    assign bx = {{2{b.x[15]}}, b.x};
    assign by = {{2{b.y[15]}}, b.y};
    assign ar = ax + {1'b0, a.w};
    assign ab = ay + {1'b0, a.h};
    assign br = bx + {1'b0, b.w};
    assign bb = by + {1'b0, b.h};

    // closed edges: sharing a border counts
    assign touch = !((ar < bx) || (br < ax) || (ab < by) || (bb < ay));

    assign rmax = (ar > br) ? ar : br;
    assign bmax = (ab > bb) ? ab : bb;
    assign mx   = (bx < ax) ? bx : ax;
    assign my   = (by < ay) ? by : ay;

    assign merged.x = mx[15:0];
    assign merged.y = my[15:0];
    assign merged.w = 17'(rmax - mx);
    assign merged.h = 17'(bmax - my);

    assign prod_full = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[31:0];
    end

    assign product = prod_reg;

endmodule

// ===== hw/rtl/dirty_rect_damage_set_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_damage_set_top
// Bounded list of disjoint damage rectangles with merge-on-add.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word: add (rect_x/y/w/h), clear, or read of
//   entry_index. rsp returns exactly one word per command: overall bounds,
//   entry count, total area (mod 2^32) and, for a read, the chosen entry.
//   Both channels use valid/ready; a word moves when both are high.
// Operation:
//   The block takes one command at a time; req.ready is high only while idle.
//   The next command can be taken in the cycle after the result has been
//   delivered. An add scans the list with one shared merge unit, one entry
//   per cycle while nothing touches; each absorbed entry is followed by a
//   swap-remove, and a pass that absorbed anything is followed by a full
//   rescan. A full list adds a waste search through the single shared
//   multiplier (steps WM, WS and WC per entry), with setup before it and
//   a fold into the least-waste entry after it. Append, summary pass and
//   result follow at the end.
// Reset:
//   rst_n clears the entry count and the sequencer; slot contents are don't
//   care until written. No clearing pass is needed.
// Stall:
//   The result holds in its register while rsp.ready is low; no new command
//   is taken until the result has been delivered.
// ----------------------------------------------------------------------------
module dirty_rect_damage_set_top
    import drds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    drds_req_if.sink   req,
    drds_rsp_if.source rsp
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ABS   = 4'd1;   // absorb scan
    localparam logic [3:0] ST_REM   = 4'd2;   // swap-remove
    localparam logic [3:0] ST_WACC  = 4'd3;   // area of acc
    localparam logic [3:0] ST_WACCR = 4'd4;
    localparam logic [3:0] ST_WM    = 4'd5;   // merged area of slot i
    localparam logic [3:0] ST_WS    = 4'd6;   // area of slot i
    localparam logic [3:0] ST_WC    = 4'd7;   // waste compare
    localparam logic [3:0] ST_WMRG  = 4'd8;   // merge with least-waste slot
    localparam logic [3:0] ST_APP   = 4'd9;
    localparam logic [3:0] ST_RD    = 4'd10;
    localparam logic [3:0] ST_SUM   = 4'd11;  // bounds and area pass
    localparam logic [3:0] ST_OUT   = 4'd12;

    // control
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic             again_reg, again_next;
    logic             phase_reg, phase_next;
    logic             rem_best_reg, rem_best_next;

    // datapath
    box_t             acc_reg, acc_next;
    box_t             bnd_reg, bnd_next;
    box_t             ent_reg, ent_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      acc_area_reg, acc_area_next;
    logic [31:0]      m_area_reg, m_area_next;
    logic [2:0]       idx_reg, idx_next;

    box_t             slot_reg [MAX_RECTS];
    logic             slot_we;
    logic [IDX_W-1:0] slot_wa;
    box_t             slot_wd;
    logic [IDX_W-1:0] rd_addr;
    box_t             slot_rd;

    box_t             alu_a;
    logic             touch;
    box_t             merged;
    logic [16:0]      mul_a, mul_b;
    logic [31:0]      product;
    logic [31:0]      waste;
    box_t             in_box;

    assign in_box.x = req.rect_x;
    assign in_box.y = req.rect_y;
    assign in_box.w = {1'b0, req.rect_w};
    assign in_box.h = {1'b0, req.rect_h};

    // single read port into the slot table
    always_comb
    begin
        unique case (state_reg)
            ST_REM:  rd_addr = count_reg[IDX_W-1:0];
            ST_WMRG: rd_addr = best_idx_reg;
            ST_RD:   rd_addr = IDX_W'(idx_reg);
            default: rd_addr = i_reg[IDX_W-1:0];
        endcase
    end

    assign slot_rd = slot_reg[rd_addr];
    assign alu_a   = (state_reg == ST_SUM) ? bnd_reg : acc_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_WACC:
            begin
                mul_a = acc_reg.w;
                mul_b = acc_reg.h;
            end
            ST_WM:
            begin
                mul_a = merged.w;
                mul_b = merged.h;
            end
            default:
            begin
                mul_a = slot_rd.w;
                mul_b = slot_rd.h;
            end
        endcase
    end

    drds_alu u_alu (
        .clk     (clk),
        .a       (alu_a),
        .b       (slot_rd),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .touch   (touch),
        .merged  (merged),
        .product (product)
    );

    assign waste = m_area_reg - acc_area_reg - product;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        again_next    = again_reg;
        phase_next    = phase_reg;
        rem_best_next = rem_best_reg;
        acc_next      = acc_reg;
        bnd_next      = bnd_reg;
        ent_next      = ent_reg;
        total_next    = total_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        acc_area_next = acc_area_reg;
        m_area_next   = m_area_reg;
        idx_next      = idx_reg;
        slot_we       = 1'b0;
        slot_wa       = i_reg[IDX_W-1:0];
        slot_wd       = slot_rd;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    acc_next   = in_box;
                    idx_next   = req.entry_index;
                    ent_next   = '0;
                    bnd_next   = '0;
                    total_next = '0;
                    i_next     = '0;
                    again_next = 1'b0;
                    phase_next = 1'b0;
                    rem_best_next = 1'b0;
                    state_next = ST_SUM;
                    if (req.cmd == CMD_ADD)
                    begin
                        if (req.rect_w > 16'sd0 && req.rect_h > 16'sd0)
                            state_next = ST_ABS;
                    end
                    else if (req.cmd == CMD_CLEAR)
                        count_next = '0;
                    else if (req.cmd == CMD_READ)
                        state_next = ST_RD;
                end
            end
            ST_ABS:
            begin
                if (i_reg < count_reg)
                begin
                    if (touch)
                    begin
                        acc_next   = merged;
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_REM;
                    end
                    else
                        i_next = i_reg + CNT_W'(1);
                end
                else if (again_reg)
                begin
                    i_next     = '0;
                    again_next = 1'b0;
                end
                else if (!phase_reg && count_reg == CNT_W'(MAX_RECTS))
                    state_next = ST_WACC;
                else
                    state_next = ST_APP;
            end
            ST_REM:
            begin
                // last entry moves into the freed slot
                slot_we = 1'b1;
                slot_wa = i_reg[IDX_W-1:0];
                slot_wd = slot_rd;
                state_next = ST_ABS;
                if (rem_best_reg)
                begin
                    rem_best_next = 1'b0;
                    phase_next    = 1'b1;
                    i_next        = '0;
                    again_next    = 1'b0;
                end
                else
                    again_next = 1'b1;
            end
            ST_WACC:
                state_next = ST_WACCR;
            ST_WACCR:
            begin
                acc_area_next = product;
                i_next        = '0;
                best_next     = '1;
                best_idx_next = '0;
                state_next    = ST_WM;
            end
            ST_WM:
                state_next = ST_WS;
            ST_WS:
            begin
                m_area_next = product;
                state_next  = ST_WC;
            end
            ST_WC:
            begin
                if (waste < best_reg)
                begin
                    best_next     = waste;
                    best_idx_next = i_reg[IDX_W-1:0];
                end
                i_next = i_reg + CNT_W'(1);
                if (i_reg + CNT_W'(1) == count_reg)
                    state_next = ST_WMRG;
                else
                    state_next = ST_WM;
            end
            ST_WMRG:
            begin
                acc_next      = merged;
                count_next    = count_reg - CNT_W'(1);
                i_next        = CNT_W'(best_idx_reg);
                rem_best_next = 1'b1;
                state_next    = ST_REM;
            end
            ST_APP:
            begin
                slot_we    = 1'b1;
                slot_wa    = count_reg[IDX_W-1:0];
                slot_wd    = acc_reg;
                count_next = count_reg + CNT_W'(1);
                i_next     = '0;
                state_next = ST_SUM;
            end
            ST_RD:
            begin
                if (8'(idx_reg) < 8'(count_reg))
                    ent_next = slot_rd;
                i_next     = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // product belongs to the slot read in the cycle before
                if (i_reg != '0)
                    total_next = total_reg + product;
                if (i_reg < count_reg)
                begin
                    bnd_next = (i_reg == '0) ? slot_rd : merged;
                    i_next   = i_reg + CNT_W'(1);
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            i_reg        <= '0;
            again_reg    <= 1'b0;
            phase_reg    <= 1'b0;
            rem_best_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            i_reg        <= i_next;
            again_reg    <= again_next;
            phase_reg    <= phase_next;
            rem_best_reg <= rem_best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        bnd_reg      <= bnd_next;
        ent_reg      <= ent_next;
        total_reg    <= total_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        acc_area_reg <= acc_area_next;
        m_area_reg   <= m_area_next;
        idx_reg      <= idx_next;
        if (slot_we)
            slot_reg[slot_wa] <= slot_wd;
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = (state_reg == ST_OUT);
    assign rsp.bounds_valid = (count_reg != '0);
    assign rsp.bound_x      = bnd_reg.x;
    assign rsp.bound_y      = bnd_reg.y;
    assign rsp.bound_w      = bnd_reg.w;
    assign rsp.bound_h      = bnd_reg.h;
    assign rsp.total_area   = total_reg;
    assign rsp.rect_count   = 4'(count_reg);
    assign rsp.entry_x      = ent_reg.x;
    assign rsp.entry_y      = ent_reg.y;
    assign rsp.entry_w      = ent_reg.w;
    assign rsp.entry_h      = ent_reg.h;

endmodule

// ===== tb/sv/tb_dirty_rect_damage_set_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dirty_rect_damage_set_top
// Self-checking bench for the damage rectangle set.
// ----------------------------------------------------------------------------
// A short table of directed commands comes first: empty reads, edge merges,
// ignored sizes, the unused command, coordinate extremes and a full list
// that forces the waste search. After that comes a long random run, mostly
// clustered adds with reads and clears mixed in, plus some full-range noise.
// Each result word is checked field by field against its typed-in word or a
// rectangle-list predictor alongside the DUT. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_dirty_rect_damage_set_top;
    import drds_pkg::*;

    // one result word, in port widths
    typedef struct packed {
        logic               bounds_valid;
        logic signed [15:0] bound_x;
        logic signed [15:0] bound_y;
        logic [16:0]        bound_w;
        logic [16:0]        bound_h;
        logic [31:0]        total_area;
        logic [3:0]         rect_count;
        logic signed [15:0] entry_x;
        logic signed [15:0] entry_y;
        logic [16:0]        entry_w;
        logic [16:0]        entry_h;
    } damage_word_t;

    // one directed row; lit set means the expected word is typed in
    typedef struct {
        logic [1:0]   cmd;
        int           x;
        int           y;
        int           w;
        int           h;
        int           idx;
        bit           lit;
        damage_word_t want;
    } cmd_row_t;

    // rectangle in wide integers so edge sums never overflow
    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } span_t;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   quiet;       // no idling on either side while set

    drds_req_if req ();
    drds_rsp_if rsp ();

    dirty_rect_damage_set_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor: the damage list as the block should hold it
    // ------------------------------------------------------------------
    span_t        dmg_list[MAX_RECTS];
    int           dmg_count;
    damage_word_t pending_words[$];

    function automatic bit spans_touch(span_t a, span_t b);
        return !(a.x + a.w < b.x || b.x + b.w < a.x ||
                 a.y + a.h < b.y || b.y + b.h < a.y);
    endfunction

    function automatic span_t span_union(span_t a, span_t b);
        longint rx;
        longint by;
        rx = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
        by = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
        if (b.x < a.x) a.x = b.x;
        if (b.y < a.y) a.y = b.y;
        a.w = rx - a.x;
        a.h = by - a.y;
        return a;
    endfunction

    function automatic logic [31:0] span_area(span_t s);
        longint p;
        p = s.w * s.h;
        return p[31:0];
    endfunction

    // swap-remove: last entry moves into the freed slot
    function automatic void drop_slot(int i);
        dmg_count--;
        dmg_list[i] = dmg_list[dmg_count];
    endfunction

    // merge in every touching entry, rescanning until stable
    function automatic span_t sweep_merges(span_t acc);
        bit again;
        int i;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            i = 0;
            while (i < dmg_count)
            begin
                if (spans_touch(acc, dmg_list[i]))
                begin
                    acc = span_union(acc, dmg_list[i]);
                    drop_slot(i);
                    again = 1'b1;
                end
                else
                    i++;
            end
        end
        return acc;
    endfunction

    function automatic void add_damage(span_t acc);
        int          best;
        logic [31:0] least_waste;
        logic [31:0] waste;
        best = 0;
        least_waste = 32'hFFFF_FFFF;
        acc = sweep_merges(acc);
        if (dmg_count == MAX_RECTS)
        begin
            // full: fold into the entry with least waste (first one on ties)
            for (int i = 0; i < dmg_count; i++)
            begin
                waste = span_area(span_union(acc, dmg_list[i])) - span_area(acc)
                        - span_area(dmg_list[i]);
                if (waste < least_waste)
                begin
                    least_waste = waste;
                    best = i;
                end
            end
            acc = span_union(acc, dmg_list[best]);
            drop_slot(best);
            acc = sweep_merges(acc);
        end
        dmg_list[dmg_count] = acc;
        dmg_count++;
    endfunction

    function automatic damage_word_t predict_damage(logic [1:0] cmd, logic [15:0] x,
                                                    logic [15:0] y, logic [15:0] w,
                                                    logic [15:0] h, logic [2:0] idx);
        damage_word_t r;
        span_t        s;
        span_t        bnd;
        logic [31:0]  total;
        r = '0;
        total = '0;
        bnd = '{0, 0, 0, 0};
        if (cmd == CMD_ADD)
        begin
            s.x = longint'($signed(x));
            s.y = longint'($signed(y));
            s.w = longint'($signed(w));
            s.h = longint'($signed(h));
            if (s.w > 0 && s.h > 0)
                add_damage(s);
        end
        else if (cmd == CMD_CLEAR)
            dmg_count = 0;
        else if (cmd == CMD_READ && int'(idx) < dmg_count)
        begin
            r.entry_x = dmg_list[idx].x[15:0];
            r.entry_y = dmg_list[idx].y[15:0];
            r.entry_w = dmg_list[idx].w[16:0];
            r.entry_h = dmg_list[idx].h[16:0];
        end
        for (int i = 0; i < dmg_count; i++)
        begin
            bnd = (i == 0) ? dmg_list[i] : span_union(bnd, dmg_list[i]);
            total += span_area(dmg_list[i]);
        end
        r.bounds_valid = (dmg_count != 0);
        r.bound_x = bnd.x[15:0];
        r.bound_y = bnd.y[15:0];
        r.bound_w = bnd.w[16:0];
        r.bound_h = bnd.h[16:0];
        r.total_area = total;
        r.rect_count = dmg_count[3:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_word(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                             logic [15:0] w, logic [15:0] h, logic [2:0] idx,
                             bit lit, damage_word_t want);
        damage_word_t pred;
        // random idle cycles ahead of the word
        while (!quiet && $urandom_range(0, 99) < 9)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= cmd;
        req.rect_x      <= x;
        req.rect_y      <= y;
        req.rect_w      <= w;
        req.rect_h      <= h;
        req.entry_index <= idx;
        do
            @(posedge clk);
        while (!req.ready);
        pred = predict_damage(cmd, x, y, w, h, idx);
        pending_words.push_back(lit ? want : pred);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and the checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp.ready <= quiet || ($urandom_range(0, 99) >= 9);
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        damage_word_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                failed = 1'b1;
            end
            else
            begin
                w = pending_words.pop_front();
                check_field("bounds_valid", w.bounds_valid, rsp.bounds_valid);
                check_field("bound_x", w.bound_x, rsp.bound_x);
                check_field("bound_y", w.bound_y, rsp.bound_y);
                check_field("bound_w", w.bound_w, rsp.bound_w);
                check_field("bound_h", w.bound_h, rsp.bound_h);
                check_field("total_area", w.total_area, rsp.total_area);
                check_field("rect_count", w.rect_count, rsp.rect_count);
                check_field("entry_x", w.entry_x, rsp.entry_x);
                check_field("entry_y", w.entry_y, rsp.entry_y);
                check_field("entry_w", w.entry_w, rsp.entry_w);
                check_field("entry_h", w.entry_h, rsp.entry_h);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table. Literal rows: empty set, a single 10x10 rect, clear.
    // ------------------------------------------------------------------
    localparam damage_word_t EMPTY_WORD = '0;
    localparam damage_word_t ONE_RECT   = '{1'b1, 16'sd0, 16'sd0, 17'd10, 17'd10,
                                            32'd100, 4'd1, 16'sd0, 16'sd0, 17'd0, 17'd0};
    localparam damage_word_t ONE_READ   = '{1'b1, 16'sd0, 16'sd0, 17'd10, 17'd10,
                                            32'd100, 4'd1, 16'sd0, 16'sd0, 17'd10, 17'd10};

    cmd_row_t directed[] = '{
        '{CMD_READ,   0, 0, 0, 0, 0, 1'b1, EMPTY_WORD},      // read on empty set
        '{CMD_ADD,    0, 0, 10, 10, 0, 1'b1, ONE_RECT},
        '{CMD_READ,   0, 0, 0, 0, 0, 1'b1, ONE_READ},
        '{CMD_READ,   0, 0, 0, 0, 7, 1'b1, ONE_RECT},        // read past the list
        '{CMD_ADD,    50, 50, 0, 5, 0, 1'b1, ONE_RECT},      // zero width ignored
        '{CMD_ADD,    50, 50, 5, -5, 0, 1'b1, ONE_RECT},     // negative height ignored
        '{CMD_ADD,    50, 50, -32768, 32767, 0, 1'b1, ONE_RECT},
        '{CMD_UNUSED, 1, 1, 1, 1, 0, 1'b1, ONE_RECT},        // unused command
        '{CMD_ADD,    10, 0, 5, 5, 0, 1'b0, EMPTY_WORD},     // shares right edge
        '{CMD_ADD,    0, 15, 3, 3, 0, 1'b0, EMPTY_WORD},     // gap below the merged rect: no touch
        '{CMD_ADD,    -32768, -32768, 32767, 32767, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    32767, 32767, 32767, 32767, 0, 1'b0, EMPTY_WORD},
        '{CMD_READ,   0, 0, 0, 0, 1, 1'b0, EMPTY_WORD},
        '{CMD_CLEAR,  0, 0, 0, 0, 0, 1'b1, EMPTY_WORD},
        // nine disjoint rects: the last one forces the waste search
        '{CMD_ADD,    0, 0, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    10, 0, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    20, 0, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    30, 0, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    0, 10, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    10, 10, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    20, 10, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    30, 10, 2, 2, 0, 1'b0, EMPTY_WORD},
        '{CMD_ADD,    15, 5, 1, 1, 0, 1'b0, EMPTY_WORD},     // least waste with the rect at (10,0)
        '{CMD_READ,   0, 0, 0, 0, 7, 1'b0, EMPTY_WORD},
        '{CMD_CLEAR,  0, 0, 0, 0, 0, 1'b1, EMPTY_WORD}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [1:0]  c;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rw;
        logic [15:0] rh;
        int          pick;

        failed = 1'b0;
        quiet = 1'b0;
        dmg_count = 0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.cmd <= CMD_ADD;
        req.rect_x <= '0;
        req.rect_y <= '0;
        req.rect_w <= '0;
        req.rect_h <= '0;
        req.entry_index <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].cmd, directed[i].x[15:0], directed[i].y[15:0],
                      directed[i].w[15:0], directed[i].h[15:0], directed[i].idx[2:0],
                      directed[i].lit, directed[i].want);

        for (int n = 0; n < 550; n++)
        begin
            quiet = (n >= 200 && n < 320);    // long run with no idling
            pick = $urandom_range(0, 99);
            c = CMD_ADD;
            // clustered small rects: merges, cascades and full-list folds
            rx = 16'($urandom_range(0, 300));
            ry = 16'($urandom_range(0, 200));
            rw = 16'($urandom_range(1, 24));
            rh = 16'($urandom_range(1, 24));
            if (pick < 4)
                c = CMD_CLEAR;
            else if (pick < 22)
                c = CMD_READ;
            else if (pick < 32)
            begin
                // full-range noise: any command, any field bits
                c = 2'($urandom_range(0, 3));
                rx = 16'($urandom);
                ry = 16'($urandom);
                rw = 16'($urandom);
                rh = 16'($urandom);
            end
            send_word(c, rx, ry, rw, rh, 3'($urandom_range(0, 7)), 1'b0, EMPTY_WORD);
        end
        req.valid <= 1'b0;
        quiet = 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (!failed && pending_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/drds_pkg.sv
hw/rtl/drds_req_if.sv
hw/rtl/drds_rsp_if.sv
hw/rtl/drds_alu.sv
hw/rtl/dirty_rect_damage_set_top.sv
tb/sv/tb_dirty_rect_damage_set_top.sv
